// ===== hdl/tilt_angle_kalman_filter_core_defines.svh =====
// assertion macros for the tilt kalman core
`ifndef TILT_ANGLE_KALMAN_FILTER_CORE_DEFINES_SVH
`define TILT_ANGLE_KALMAN_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define TAKF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("takf assertion failed");

// next-cycle implication
`define TAKF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("takf assertion failed");

`endif

// ===== hdl/takf_pkg.sv =====
package takf_pkg;

  localparam int CW = 60;

  localparam logic [63:0] PI_Q32      = 64'd13493037705;
  localparam logic [63:0] RAD2DEG_Q32 = 64'd246083499208;

  localparam logic [1:0] REG_GYRO_BIAS     = 2'd0;
  localparam logic [1:0] REG_ANGLE_NOISE   = 2'd1;
  localparam logic [1:0] REG_BIAS_NOISE    = 2'd2;
  localparam logic [1:0] REG_MEASURE_NOISE = 2'd3;

  localparam logic [31:0] ANGLE_NOISE_RST   = 32'd4294967;
  localparam logic [31:0] BIAS_NOISE_RST    = 32'd12884902;
  localparam logic [31:0] MEASURE_NOISE_RST = 32'd128849019;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [4:0] SL_ANG    = 5'd0;
  localparam logic [4:0] SL_BIA    = 5'd1;
  localparam logic [4:0] SL_CAA    = 5'd2;
  localparam logic [4:0] SL_CAB    = 5'd3;
  localparam logic [4:0] SL_CBA    = 5'd4;
  localparam logic [4:0] SL_CBB    = 5'd5;
  localparam logic [4:0] SL_MEAS   = 5'd6;
  localparam logic [4:0] SL_RATE   = 5'd7;
  localparam logic [4:0] SL_DT     = 5'd8;
  localparam logic [4:0] SL_TMP    = 5'd9;
  localparam logic [4:0] SL_DP     = 5'd10;
  localparam logic [4:0] SL_S      = 5'd11;
  localparam logic [4:0] SL_K0     = 5'd12;
  localparam logic [4:0] SL_K1     = 5'd13;
  localparam logic [4:0] SL_Y      = 5'd14;
  localparam logic [4:0] SL_OMK    = 5'd15;
  localparam logic [4:0] SL_Z      = 5'd16;
  localparam logic [4:0] SL_ANOISE = 5'd17;
  localparam logic [4:0] SL_BNOISE = 5'd18;
  localparam logic [4:0] SL_MNOISE = 5'd19;
  localparam logic [4:0] SL_ONE    = 5'd20;
  localparam logic [4:0] SL_RAD    = 5'd21;

  localparam logic [4:0] LAST_PC = 5'd28;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] d;
  } uop_t;

  typedef logic [31:0][63:0] atan_tab_t;

  function automatic uop_t takf_ucode(input logic [4:0] pc);
    uop_t u;
    case (pc)
      5'd0:  u = '{OP_MUL, SL_Z,    SL_RAD,    SL_MEAS};
      5'd1:  u = '{OP_SUB, SL_RATE, SL_BIA,    SL_TMP};
      5'd2:  u = '{OP_MUL, SL_TMP,  SL_DT,     SL_TMP};
      5'd3:  u = '{OP_ADD, SL_ANG,  SL_TMP,    SL_ANG};
      5'd4:  u = '{OP_MUL, SL_DT,   SL_CBB,    SL_DP};
      5'd5:  u = '{OP_SUB, SL_DP,   SL_CAB,    SL_TMP};
      5'd6:  u = '{OP_SUB, SL_TMP,  SL_CBA,    SL_TMP};
      5'd7:  u = '{OP_ADD, SL_TMP,  SL_ANOISE, SL_TMP};
      5'd8:  u = '{OP_MUL, SL_DT,   SL_TMP,    SL_TMP};
      5'd9:  u = '{OP_ADD, SL_CAA,  SL_TMP,    SL_CAA};
      5'd10: u = '{OP_SUB, SL_CAB,  SL_DP,     SL_CAB};
      5'd11: u = '{OP_SUB, SL_CBA,  SL_DP,     SL_CBA};
      5'd12: u = '{OP_MUL, SL_BNOISE, SL_DT,   SL_TMP};
      5'd13: u = '{OP_ADD, SL_CBB,  SL_TMP,    SL_CBB};
      5'd14: u = '{OP_ADD, SL_CAA,  SL_MNOISE, SL_S};
      5'd15: u = '{OP_DIV, SL_CAA,  SL_S,      SL_K0};
      5'd16: u = '{OP_DIV, SL_CBA,  SL_S,      SL_K1};
      5'd17: u = '{OP_SUB, SL_MEAS, SL_ANG,    SL_Y};
      5'd18: u = '{OP_MUL, SL_K0,   SL_Y,      SL_TMP};
      5'd19: u = '{OP_ADD, SL_ANG,  SL_TMP,    SL_ANG};
      5'd20: u = '{OP_MUL, SL_K1,   SL_Y,      SL_TMP};
      5'd21: u = '{OP_ADD, SL_BIA,  SL_TMP,    SL_BIA};
      5'd22: u = '{OP_SUB, SL_ONE,  SL_K0,     SL_OMK};
      5'd23: u = '{OP_MUL, SL_K1,   SL_CAA,    SL_TMP};
      5'd24: u = '{OP_SUB, SL_CBA,  SL_TMP,    SL_CBA};
      5'd25: u = '{OP_MUL, SL_K1,   SL_CAB,    SL_TMP};
      5'd26: u = '{OP_SUB, SL_CBB,  SL_TMP,    SL_CBB};
      5'd27: u = '{OP_MUL, SL_OMK,  SL_CAA,    SL_CAA};
      5'd28: u = '{OP_MUL, SL_OMK,  SL_CAB,    SL_CAB};
      default: u = '{OP_ADD, SL_TMP, SL_TMP,   SL_TMP};
    endcase
    return u;
  endfunction

  // atan(2^-i) in radians, 32 fraction bits, from the series
  function automatic atan_tab_t takf_atan_table();
    atan_tab_t tab;
    logic [63:0] sum;
    logic [63:0] term;
    int e;
    for (int i = 0; i < 32; i++) begin
      if (i == 0) begin
        tab[i] = 64'd3373259426;
      end else begin
        sum = '0;
        for (int k = 0; k < 32; k++) begin
          e = i * (2 * k + 1);
          if (e <= 62) begin
            term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
          end
        end
        tab[i] = (sum + (64'd1 << 29)) >> 30;
      end
    end
    return tab;
  endfunction

endpackage

// ===== hdl/tilt_angle_kalman_filter_core.sv =====
// an input beat runs through the cordic steps and then the filter microcode: products on a shared
// 32x32 multiplier, gains on a one-bit-a-cycle divider, adds and subtracts on the saturating adder
// input stalled while an item is worked on, so a new beat is taken only once the result is loaded
// reset: synchronous active-low rst_n clears filter state, sequencer and output valid,
// and loads the register defaults
module tilt_angle_kalman_filter_core #(
  parameter int CORDIC_STEPS   = 24,
  parameter int INTERNAL_WIDTH = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_accel_y,
  input  logic signed [31:0] in_accel_z,
  input  logic signed [31:0] in_gyro_rate,
  input  logic [31:0]        in_time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_filtered_angle,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import takf_pkg::*;

  localparam int W     = INTERNAL_WIDTH;
  localparam int ACC_W = 2 * W;
  localparam int MW    = 2 * W - 32;
  localparam int DVD_W = W + 32;
  localparam int DCW   = $clog2(DVD_W + 1);

  localparam logic signed [W-1:0] WMAX_C = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN_C = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE_C  = {{(W-33){1'b0}}, 1'b1, 32'b0};
  localparam atan_tab_t ATAN_TAB = takf_atan_table();
  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CORD = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_MULF = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_DIVF = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_r;
  logic [4:0] pc_r;
  logic [4:0] ci_r;
  logic [2:0] mcnt_r;
  logic [DCW-1:0] dcnt_r;

  logic signed [31:0] gbias_r;
  logic [31:0] anoise_r, bnoise_r, mnoise_r;

  logic signed [W-1:0] ang_r, bia_r, caa_r, cab_r, cba_r, cbb_r;
  logic signed [W-1:0] meas_r, rate_r, dt_r, tmp_r, dp_r, s_r, k0_r, k1_r, y_r, omk_r, z_r;
  logic signed [CW-1:0] cx_r, cy_r;

  logic [W-1:0] mam_r, mbm_r;
  logic neg_r;
  logic [63:0] prod_r;
  logic [ACC_W-1:0] acc_r;
  logic [DVD_W-1:0] dvd_r;
  logic [W-1:0] rem_r, q_r;
  logic ovf_r;

  logic out_valid_r, out_sat_r;
  logic signed [31:0] out_angle_r;

  uop_t uop;
  logic signed [W-1:0] opa, opb;
  logic [W-1:0] am, bm;
  logic signed [W:0] alu_ext;
  logic signed [W-1:0] alu_res;
  logic wr_en;
  logic signed [W-1:0] wr_val;
  logic [31:0] pa, pb;
  logic [ACC_W-1:0] addend;
  logic [MW-1:0] mhi;
  logic [MW:0] mr, mlim;
  logic [W-1:0] mrw;
  logic signed [W-1:0] mul_res;
  logic [W:0] rem_sh, qlim;
  logic div_ge;
  logic signed [W-1:0] div_res;
  logic signed [64:0] rdiff;
  logic signed [W-1:0] rate_in;
  logic signed [CW-1:0] xs, ys;
  logic signed [CW-1:0] dx, dy;
  logic signed [W-1:0] at;
  logic signed [64:0] ae;
  logic signed [31:0] a_clip;
  logic a_sat;
  logic in_acc, out_free;

  function automatic logic signed [W-1:0] rd(input logic [4:0] sel);
    logic signed [W-1:0] v;
    case (sel)
      SL_ANG:    v = ang_r;
      SL_BIA:    v = bia_r;
      SL_CAA:    v = caa_r;
      SL_CAB:    v = cab_r;
      SL_CBA:    v = cba_r;
      SL_CBB:    v = cbb_r;
      SL_MEAS:   v = meas_r;
      SL_RATE:   v = rate_r;
      SL_DT:     v = dt_r;
      SL_TMP:    v = tmp_r;
      SL_DP:     v = dp_r;
      SL_S:      v = s_r;
      SL_K0:     v = k0_r;
      SL_K1:     v = k1_r;
      SL_Y:      v = y_r;
      SL_OMK:    v = omk_r;
      SL_Z:      v = z_r;
      SL_ANOISE: v = {{(W-32){1'b0}}, anoise_r};
      SL_BNOISE: v = {{(W-32){1'b0}}, bnoise_r};
      SL_MNOISE: v = {{(W-32){1'b0}}, mnoise_r};
      SL_ONE:    v = ONE_C;
      SL_RAD:    v = W'(RAD2DEG_Q32);
      default:   v = '0;
    endcase
    return v;
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // operand fetch and add/sub with saturation
  always_comb begin
    uop = takf_ucode(pc_r);
    opa = rd(uop.a);
    opb = rd(uop.b);
    am  = opa[W-1] ? (~opa + 1'b1) : opa;
    bm  = opb[W-1] ? (~opb + 1'b1) : opb;
    if (uop.op == OP_SUB) alu_ext = {opa[W-1], opa} - {opb[W-1], opb};
    else alu_ext = {opa[W-1], opa} + {opb[W-1], opb};
    if (alu_ext[W] != alu_ext[W-1]) alu_res = alu_ext[W] ? WMIN_C : WMAX_C;
    else alu_res = alu_ext[W-1:0];
  end

  // multiplier: partial products and final floor and clip
  always_comb begin
    case (mcnt_r)
      3'd0:    begin pa = mam_r[31:0];       pb = mbm_r[31:0];       end
      3'd1:    begin pa = mam_r[31:0];       pb = 32'(mbm_r >> 32);  end
      3'd2:    begin pa = 32'(mam_r >> 32);  pb = mbm_r[31:0];       end
      default: begin pa = 32'(mam_r >> 32);  pb = 32'(mbm_r >> 32);  end
    endcase
    case (mcnt_r)
      3'd2, 3'd3: addend = ACC_W'(prod_r) << 32;
      3'd4:       addend = ACC_W'(prod_r) << 64;
      default:    addend = ACC_W'(prod_r);
    endcase
    mhi  = acc_r[ACC_W-1:32];
    mr   = {1'b0, mhi} + (MW+1)'(neg_r && (acc_r[31:0] != 32'd0));
    mlim = (MW+1)'(WMAX_C) + (MW+1)'(neg_r);
    mrw  = mr[W-1:0];
    if (mr > mlim) mul_res = neg_r ? WMIN_C : WMAX_C;
    else mul_res = neg_r ? (~mrw + 1'b1) : mrw;
  end

  // divider step and final clip
  always_comb begin
    rem_sh = {rem_r, dvd_r[DVD_W-1]};
    div_ge = rem_sh >= {1'b0, mbm_r};
    qlim   = (W+1)'(WMAX_C) + (W+1)'(neg_r);
    if (ovf_r || ({1'b0, q_r} > qlim)) div_res = neg_r ? WMIN_C : WMAX_C;
    else div_res = neg_r ? (~q_r + 1'b1) : q_r;
  end

  // write-back select
  always_comb begin
    wr_en  = 1'b0;
    wr_val = alu_res;
    case (state_r)
      ST_EXEC: begin
        if (uop.op == OP_ADD || uop.op == OP_SUB) begin
          wr_en = 1'b1;
        end else if (uop.op == OP_DIV && opb == '0) begin
          wr_en  = 1'b1;
          wr_val = '0;
        end
      end
      ST_MULF: begin
        wr_en  = 1'b1;
        wr_val = mul_res;
      end
      ST_DIVF: begin
        wr_en  = 1'b1;
        wr_val = div_res;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // input capture, cordic step, output clip
  always_comb begin
    rdiff = (65'(in_gyro_rate) - 65'(gbias_r)) <<< 16;
    if (rdiff > 65'(WMAX_C)) rate_in = WMAX_C;
    else if (rdiff < 65'(WMIN_C)) rate_in = WMIN_C;
    else rate_in = W'(rdiff);
    xs = CW'(in_accel_z);
    ys = CW'(in_accel_y);
    if (in_accel_z < 0) begin
      xs = -xs;
      ys = -ys;
    end
    dx = cy_r >>> ci_r;
    dy = cx_r >>> ci_r;
    at = W'(ATAN_TAB[ci_r]);
    ae = 65'(ang_r) >>> 16;
    a_sat = 1'b0;
    a_clip = 32'(ae);
    if (ae > 65'sd2147483647) begin
      a_clip = 32'h7fff_ffff;
      a_sat  = 1'b1;
    end else if (ae < -65'sd2147483648) begin
      a_clip = 32'h8000_0000;
      a_sat  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      gbias_r     <= '0;
      anoise_r    <= ANGLE_NOISE_RST;
      bnoise_r    <= BIAS_NOISE_RST;
      mnoise_r    <= MEASURE_NOISE_RST;
      ang_r       <= '0;
      bia_r       <= '0;
      caa_r       <= '0;
      cab_r       <= '0;
      cba_r       <= '0;
      cbb_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GYRO_BIAS:     gbias_r  <= cfg_wdata;
          REG_ANGLE_NOISE:   anoise_r <= cfg_wdata;
          REG_BIAS_NOISE:    bnoise_r <= cfg_wdata;
          REG_MEASURE_NOISE: mnoise_r <= cfg_wdata;
          default:           gbias_r  <= gbias_r;
        endcase
      end

      if (out_valid_r && !out_stall && state_r != ST_OUT) out_valid_r <= 1'b0;

      if (wr_en) begin
        case (uop.d)
          SL_ANG:  ang_r  <= wr_val;
          SL_BIA:  bia_r  <= wr_val;
          SL_CAA:  caa_r  <= wr_val;
          SL_CAB:  cab_r  <= wr_val;
          SL_CBA:  cba_r  <= wr_val;
          SL_CBB:  cbb_r  <= wr_val;
          SL_MEAS: meas_r <= wr_val;
          SL_DP:   dp_r   <= wr_val;
          SL_S:    s_r    <= wr_val;
          SL_K0:   k0_r   <= wr_val;
          SL_K1:   k1_r   <= wr_val;
          SL_Y:    y_r    <= wr_val;
          SL_OMK:  omk_r  <= wr_val;
          default: tmp_r  <= wr_val;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            rate_r <= rate_in;
            dt_r   <= {{(W-32){1'b0}}, in_time_step};
            cx_r   <= xs <<< 24;
            cy_r   <= ys <<< 24;
            ci_r   <= '0;
            pc_r   <= '0;
            if (in_accel_z < 0) z_r <= (in_accel_y >= 0) ? W'(PI_Q32) : -W'(PI_Q32);
            else z_r <= '0;
            if (in_accel_y == 0 && in_accel_z == 0) begin
              state_r <= ST_EXEC;
            end else begin
              state_r <= ST_CORD;
            end
          end
        end
        ST_CORD: begin
          if (!cy_r[CW-1]) begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r - dy;
            z_r  <= z_r + at;
          end else begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r + dy;
            z_r  <= z_r - at;
          end
          ci_r <= ci_r + 5'd1;
          if (ci_r == LAST_STEP) state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          neg_r  <= opa[W-1] ^ opb[W-1];
          mam_r  <= am;
          mbm_r  <= bm;
          acc_r  <= '0;
          mcnt_r <= '0;
          dvd_r  <= {am, 32'b0};
          rem_r  <= '0;
          q_r    <= '0;
          ovf_r  <= 1'b0;
          dcnt_r <= '0;
          if (uop.op == OP_MUL) begin
            state_r <= ST_MUL;
          end else if (uop.op == OP_DIV && opb != '0) begin
            state_r <= ST_DIV;
          end else if (pc_r == LAST_PC) begin
            state_r <= ST_OUT;
          end else begin
            pc_r <= pc_r + 5'd1;
          end
        end
        ST_MUL: begin
          if (mcnt_r != 3'd4) prod_r <= 64'(pa) * 64'(pb);
          if (mcnt_r != 3'd0) acc_r <= acc_r + addend;
          mcnt_r <= mcnt_r + 3'd1;
          if (mcnt_r == 3'd4) state_r <= ST_MULF;
        end
        ST_DIV: begin
          rem_r  <= div_ge ? rem_sh[W-1:0] - mbm_r : rem_sh[W-1:0];
          q_r    <= {q_r[W-2:0], div_ge};
          ovf_r  <= ovf_r | q_r[W-1];
          dvd_r  <= dvd_r << 1;
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DCW'(DVD_W - 1)) state_r <= ST_DIVF;
        end
        ST_MULF, ST_DIVF: begin
          if (pc_r == LAST_PC) begin
            state_r <= ST_OUT;
          end else begin
            pc_r    <= pc_r + 5'd1;
            state_r <= ST_EXEC;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_angle_r <= a_clip;
            out_sat_r   <= a_sat;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_filtered_angle = out_angle_r;
  assign out_saturated      = out_sat_r;

`include "tilt_angle_kalman_filter_core_defines.svh"

  `TAKF_ASSERT_NXT(a_accept_starts, in_acc, state_r == ST_CORD || state_r == ST_EXEC)
  `TAKF_ASSERT_IMP(a_mul_count, state_r == ST_MUL, mcnt_r <= 3'd4)
  `TAKF_ASSERT_NXT(a_out_load, state_r == ST_OUT && out_free, out_valid_r && state_r == ST_IDLE)
  `TAKF_ASSERT_IMP(a_pc_range, state_r == ST_EXEC, pc_r <= LAST_PC)

endmodule
